>>> rtl/lru_page_replacement_core_assert.svh
// Assertion macros for the LRU page replacement core.
`ifndef LRU_PAGE_REPLACEMENT_CORE_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LRU_PR_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LRU_PR_ASSERT(lbl, prop, msg) \
  `LRU_PR_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define LRU_PR_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define LRU_PR_ASSERT(lbl, prop, msg)
`endif
`endif

>>> rtl/lru_pr_pkg.sv
// Types and constants shared by the LRU page replacement modules.
package lru_pr_pkg;

  localparam int MAX_FRAMES = 8;
  localparam int PAGE_BITS  = 16;
  localparam int IDX_W      = 3;
  localparam int RANK_W     = 3;
  localparam int CFG_W      = 4;
  localparam int CNT_W      = 32;

  localparam logic [CFG_W-1:0] FramesInUseReset = CFG_W'(8);

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [RANK_W-1:0]    rank_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // Outcome of one lookup, applied to the frame store on commit
  typedef struct packed {
    logic  hit;
    logic  fill;
    logic  evict;
    idx_t  slot;
    rank_t old_rank;
    page_t evicted_page;
  } decision_t;

endpackage

>>> rtl/lru_pr_select.sv
// Tag compare, empty-frame search and LRU victim choice for one reference.
module lru_pr_select (
  input  lru_pr_pkg::page_t                                page_i,
  input  logic [lru_pr_pkg::CFG_W-1:0]                     frames_in_use_i,
  input  lru_pr_pkg::page_t [lru_pr_pkg::MAX_FRAMES-1:0]   frame_page_i,
  input  logic [lru_pr_pkg::MAX_FRAMES-1:0]                frame_valid_i,
  input  lru_pr_pkg::rank_t [lru_pr_pkg::MAX_FRAMES-1:0]   frame_rank_i,
  output lru_pr_pkg::decision_t                            dec_o
);

  logic [lru_pr_pkg::CFG_W-1:0]      used;
  logic [lru_pr_pkg::MAX_FRAMES-1:0] in_use;
  logic                              hit, empty;
  lru_pr_pkg::idx_t                  hit_slot, empty_slot, lru_slot;
  lru_pr_pkg::rank_t                 lru_rank;

  always_comb begin
    if (frames_in_use_i == '0) begin
      used = lru_pr_pkg::CFG_W'(1);
    end else if (frames_in_use_i > lru_pr_pkg::CFG_W'(lru_pr_pkg::MAX_FRAMES)) begin
      used = lru_pr_pkg::CFG_W'(lru_pr_pkg::MAX_FRAMES);
    end else begin
      used = frames_in_use_i;
    end
    for (int i = 0; i < lru_pr_pkg::MAX_FRAMES; i++) begin
      in_use[i] = lru_pr_pkg::CFG_W'(i) < used;
    end
  end

  // Lowest index wins: duplicates can exist after frames_in_use shrinks and grows
  always_comb begin
    hit        = 1'b0;
    hit_slot   = '0;
    empty      = 1'b0;
    empty_slot = '0;
    lru_slot   = '0;
    lru_rank   = frame_rank_i[0];
    for (int i = 0; i < lru_pr_pkg::MAX_FRAMES; i++) begin
      if (!hit && in_use[i] && frame_valid_i[i] && frame_page_i[i] == page_i) begin
        hit      = 1'b1;
        hit_slot = lru_pr_pkg::IDX_W'(i);
      end
      if (!empty && in_use[i] && !frame_valid_i[i]) begin
        empty      = 1'b1;
        empty_slot = lru_pr_pkg::IDX_W'(i);
      end
      if (i > 0 && in_use[i] && frame_rank_i[i] > lru_rank) begin
        lru_rank = frame_rank_i[i];
        lru_slot = lru_pr_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    dec_o              = '0;
    dec_o.hit          = hit;
    if (hit) begin
      dec_o.slot     = hit_slot;
      dec_o.old_rank = frame_rank_i[hit_slot];
    end else if (empty) begin
      dec_o.fill = 1'b1;
      dec_o.slot = empty_slot;
    end else begin
      dec_o.evict        = 1'b1;
      dec_o.slot         = lru_slot;
      dec_o.old_rank     = lru_rank;
      dec_o.evicted_page = frame_page_i[lru_slot];
    end
  end

endmodule

>>> rtl/lru_pr_frame_store.sv
// Frame registers: page, valid bit and recency rank, updated on commit.
module lru_pr_frame_store (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             commit_i,
  input  lru_pr_pkg::page_t                                page_i,
  input  lru_pr_pkg::decision_t                            dec_i,
  output lru_pr_pkg::page_t [lru_pr_pkg::MAX_FRAMES-1:0]   frame_page_o,
  output logic [lru_pr_pkg::MAX_FRAMES-1:0]                frame_valid_o,
  output lru_pr_pkg::rank_t [lru_pr_pkg::MAX_FRAMES-1:0]   frame_rank_o
);

  lru_pr_pkg::page_t [lru_pr_pkg::MAX_FRAMES-1:0] page_q, page_d;
  logic [lru_pr_pkg::MAX_FRAMES-1:0]              valid_q, valid_d;
  lru_pr_pkg::rank_t [lru_pr_pkg::MAX_FRAMES-1:0] rank_q, rank_d;

  // Touched frame goes to rank 0; valid frames younger than it age by one.
  // A fill ages every valid frame.
  always_comb begin
    page_d  = page_q;
    valid_d = valid_q;
    rank_d  = rank_q;
    if (commit_i) begin
      for (int i = 0; i < lru_pr_pkg::MAX_FRAMES; i++) begin
        if (lru_pr_pkg::IDX_W'(i) == dec_i.slot) begin
          rank_d[i] = '0;
          if (!dec_i.hit) begin
            page_d[i]  = page_i;
            valid_d[i] = 1'b1;
          end
        end else if (valid_q[i] && (dec_i.fill || rank_q[i] < dec_i.old_rank)) begin
          rank_d[i] = lru_pr_pkg::RANK_W'(rank_q[i] + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rank_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

  assign frame_page_o  = page_q;
  assign frame_valid_o = valid_q;
  assign frame_rank_o  = rank_q;

endmodule

>>> rtl/lru_page_replacement_core.sv
// Top level of the fully associative LRU page replacement core.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------------
//  in       | in_valid_i / in_ready_o | page_number_i
//  out      | out_valid_o/out_ready_i | was_hit_o frame_index_o evicted_valid_o
//           |                         | evicted_page_o fault_total_o hit_total_o
//  cfg      | cfg_valid_i/cfg_ready_o | cfg_data_i (frames_in_use)
//
// One reference per cycle while the output is not stalled: input register, one
// pass of compare/select/rank update, then the result register, which loads
// the outcome of that pass whenever the output is free.
// Valid bits and ranks are cleared at reset; no clearing pass is needed.
// A stalled output holds the result; the input register still takes one
// more transaction, after which in_ready_o follows out_ready_i.
`include "lru_page_replacement_core_assert.svh"
module lru_page_replacement_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  lru_pr_pkg::page_t                page_number_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             was_hit_o,
  output lru_pr_pkg::idx_t                 frame_index_o,
  output logic                             evicted_valid_o,
  output lru_pr_pkg::page_t                evicted_page_o,
  output lru_pr_pkg::cnt_t                 fault_total_o,
  output lru_pr_pkg::cnt_t                 hit_total_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lru_pr_pkg::CFG_W-1:0]     cfg_data_i
);

  logic                         s_valid_q;
  lru_pr_pkg::page_t            s_page_q;
  logic                         out_valid_q;
  logic                         hit_q, evict_q;
  lru_pr_pkg::idx_t             slot_q;
  lru_pr_pkg::page_t            evicted_page_q;
  lru_pr_pkg::cnt_t             faults_q, faults_d, hits_q, hits_d;
  logic [lru_pr_pkg::CFG_W-1:0] fiu_q;

  logic                                            out_free, adv;
  lru_pr_pkg::decision_t                           dec;
  lru_pr_pkg::page_t [lru_pr_pkg::MAX_FRAMES-1:0]  frame_page;
  logic [lru_pr_pkg::MAX_FRAMES-1:0]               frame_valid;
  lru_pr_pkg::rank_t [lru_pr_pkg::MAX_FRAMES-1:0]  frame_rank;

  assign out_free    = !out_valid_q || out_ready_i;
  assign adv         = s_valid_q && out_free;
  assign in_ready_o  = !s_valid_q || out_free;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiu_q <= lru_pr_pkg::FramesInUseReset;
    end else if (cfg_valid_i) begin
      fiu_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s_page_q <= page_number_i;
    end
  end

  lru_pr_select u_select (
    .page_i          (s_page_q),
    .frames_in_use_i (fiu_q),
    .frame_page_i    (frame_page),
    .frame_valid_i   (frame_valid),
    .frame_rank_i    (frame_rank),
    .dec_o           (dec)
  );

  lru_pr_frame_store u_frames (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .commit_i      (adv),
    .page_i        (s_page_q),
    .dec_i         (dec),
    .frame_page_o  (frame_page),
    .frame_valid_o (frame_valid),
    .frame_rank_o  (frame_rank)
  );

  // Saturating totals
  always_comb begin
    faults_d = faults_q;
    hits_d   = hits_q;
    if (dec.hit) begin
      if (hits_q != '1) hits_d = hits_q + 1'b1;
    end else begin
      if (faults_q != '1) faults_d = faults_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      faults_q    <= '0;
      hits_q      <= '0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
      faults_q    <= faults_d;
      hits_q      <= hits_d;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q          <= dec.hit;
      evict_q        <= dec.evict;
      slot_q         <= dec.slot;
      evicted_page_q <= dec.evicted_page;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign was_hit_o       = hit_q;
  assign frame_index_o   = slot_q;
  assign evicted_valid_o = evict_q;
  assign evicted_page_o  = evicted_page_q;
  assign fault_total_o   = faults_q;
  assign hit_total_o     = hits_q;

  `LRU_PR_ASSERT(a_hit_no_evict, out_valid_q |-> !(hit_q && evict_q), "hit result also evicts")
  `LRU_PR_ASSERT(a_evict_page_zero,
                 (out_valid_q && !evict_q) |-> (evicted_page_q == '0),
                 "evicted page not zero without eviction")
  `LRU_PR_ASSERT(a_fill_grows,
                 (adv && dec.fill) |=>
                   ($countones(frame_valid) == $countones($past(frame_valid)) + 1),
                 "fill did not set one valid bit")
  `LRU_PR_ASSERT(a_hit_count,
                 (adv && dec.hit) |=> ((hits_q == $past(hits_q) + 1'b1) || (hits_q == '1)),
                 "hit total not advanced")

endmodule
